@@ design/assert_macros.svh @@
// Assertion macros shared by the mailbox RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ design/cmm_pkg.sv @@
// Types and constants of the CAN message mailbox.
`timescale 1ns / 1ps
`default_nettype none

package cmm_pkg;

	localparam int unsigned ID_W     = 29;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned TS_W     = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_W    = 32;

	localparam logic [2:0]        LAST_BYTE      = 3'd7;
	localparam logic [LEN_W-1:0]  MAX_LEN        = 4'd8;
	localparam logic [LEN_W-1:0]  MIN_LEN        = 4'd1;
	localparam logic [TIME_W-1:0] RST_PERIOD_MS  = 32'd1000;

	typedef enum logic [2:0] {
		MODE_READ     = 3'd0,
		MODE_SPY      = 3'd1,
		MODE_CHANGE   = 3'd2,
		MODE_PERIODIC = 3'd3,
		MODE_BOTH     = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_POLL = 2'd0,
		CMD_SET  = 2'd1,
		CMD_TRIG = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_FRAME_ID  = 3'd1,
		REG_EXTENDED  = 3'd2,
		REG_LENGTH    = 3'd3,
		REG_PERIOD    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] now_ms;
		logic [3:0]        byte_index;
		logic [7:0]        data_value;
		logic              rx_valid;
		logic [ID_W-1:0]   rx_id;
		logic              rx_extended;
		logic [LEN_W-1:0]  rx_len;
		logic [DATA_W-1:0] rx_data;
		logic [TS_W-1:0]   rx_timestamp;
	} cmd_item_t;

	typedef struct packed {
		logic              tx_valid;
		logic [ID_W-1:0]   frame_id;
		logic              frame_extended;
		logic [LEN_W-1:0]  frame_len;
		logic [DATA_W-1:0] frame_data;
		logic              new_data;
		logic [TS_W-1:0]   frame_timestamp;
	} res_item_t;

	typedef struct packed {
		logic [2:0]       index;
		logic [CFG_W-1:0] wdata;
	} cfg_item_t;

	// Mailbox contents and send bookkeeping
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              ext;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic [TS_W-1:0]   ts;
		logic              pending;
		logic              prev_trig;
		logic [TIME_W-1:0] last_send;
		logic              fresh;
	} state_t;

endpackage

`default_nettype wire

@@ design/cmm_chan_if.sv @@
// Valid/ready channel carrying one payload item.
`timescale 1ns / 1ps
`default_nettype none

interface cmm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/can_message_mailbox.sv @@
// Top level of the single-frame CAN message mailbox.
// Channels: cmd (sink) takes poll, set-data and trigger items; res (source)
// gives one result item per command item: tx_valid plus the stored frame as
// it stands after that item. cfg (sink) writes mode, identifier, format flag,
// length and send period by register index; it is always ready and must only
// be written while no command item is in flight.
// Path: an accepted item is held in the input register, and its result is
// written to the result register and sits on res once the item advances.
// Throughput: one item per cycle while res is taken; the update is one pass
// of compare, 32-bit subtract and select logic between input and result registers.
// Stalls: while res is not taken, the result register holds and the input
// register can still take one more item before cmd.ready drops.
// Reset: arst_n clears the frame to id 0, standard format, length 8, data
// and timestamp 0, no send pending, mode read, period 1000 ms.
`timescale 1ns / 1ps
`default_nettype none

module can_message_mailbox (
	input  logic        clk,
	input  logic        arst_n,
	cmm_chan_if.sink    cmd,
	cmm_chan_if.source  res,
	cmm_chan_if.sink    cfg
);

	`include "assert_macros.svh"

	cmm_pkg::cmd_item_t item_s1;
	logic               valid_s1;
	cmm_pkg::state_t    st_q;
	cmm_pkg::state_t    nxt_st;
	cmm_pkg::mode_t     mode_q;
	logic [31:0]        period_q;
	cmm_pkg::res_item_t res_q;
	logic               res_valid_q;
	logic               nxt_tx;
	logic               advance;
	logic               cfg_wr;
	cmm_pkg::cfg_item_t cfg_item;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;
	assign cfg_item  = cfg.data;

	cmm_update u_update (
		.st     (st_q),
		.mode   (mode_q),
		.period (period_q),
		.item   (item_s1),
		.nxt    (nxt_st),
		.tx     (nxt_tx)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready)
			item_s1 <= cmd.data;
	end

	// mailbox state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '{id: '0, ext: 1'b0, len: cmm_pkg::MAX_LEN, data: '0, ts: '0,
				pending: 1'b0, prev_trig: 1'b0, last_send: '0, fresh: 1'b0};
			mode_q   <= cmm_pkg::MODE_READ;
			period_q <= cmm_pkg::RST_PERIOD_MS;
		end else begin
			if (advance)
				st_q <= nxt_st;
			if (cfg_wr) begin
				unique case (cmm_pkg::reg_idx_t'(cfg_item.index))
					cmm_pkg::REG_MODE: begin
						if (cfg_item.wdata[2:0] <= cmm_pkg::MODE_BOTH)
							mode_q <= cmm_pkg::mode_t'(cfg_item.wdata[2:0]);
					end
					cmm_pkg::REG_FRAME_ID: begin
						st_q.id <= cfg_item.wdata[cmm_pkg::ID_W-1:0];
					end
					cmm_pkg::REG_EXTENDED: begin
						st_q.ext <= cfg_item.wdata[0];
					end
					cmm_pkg::REG_LENGTH: begin
						if (cfg_item.wdata[3:0] >= cmm_pkg::MIN_LEN &&
							cfg_item.wdata[3:0] <= cmm_pkg::MAX_LEN)
							st_q.len <= cfg_item.wdata[3:0];
					end
					cmm_pkg::REG_PERIOD: begin
						period_q <= cfg_item.wdata;
					end
					default: begin
						period_q <= period_q;
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.tx_valid        <= nxt_tx;
			res_q.frame_id        <= nxt_st.id;
			res_q.frame_extended  <= nxt_st.ext;
			res_q.frame_len       <= nxt_st.len;
			res_q.frame_data      <= nxt_st.data;
			res_q.new_data        <= nxt_st.fresh;
			res_q.frame_timestamp <= nxt_st.ts;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	`ASSERT_NXT(a_adv_fills_res, advance, res_valid_q)
	`ASSERT_NXT(a_s1_kept, valid_s1 && !advance, valid_s1)
	`ASSERT_NXT(a_tx_clears_pending, advance && nxt_tx, !st_q.pending)
	`ASSERT_IMP(a_len_range, 1'b1, st_q.len <= cmm_pkg::MAX_LEN)

endmodule

`default_nettype wire

@@ design/cmm_update.sv @@
// Next-state and result logic for one mailbox item.
`timescale 1ns / 1ps
`default_nettype none

module cmm_update (
	input  cmm_pkg::state_t    st,
	input  cmm_pkg::mode_t     mode,
	input  logic [31:0]        period,
	input  cmm_pkg::cmd_item_t item,
	output cmm_pkg::state_t    nxt,
	output logic               tx
);

	logic        rx_match;
	logic [31:0] elapsed;
	logic        due;
	logic [5:0]  sh;
	logic [7:0]  old_byte;
	logic        level;

	assign elapsed  = item.now_ms - st.last_send;
	assign sh       = {item.byte_index[2:0], 3'b000};
	assign old_byte = st.data[sh +: 8];
	assign level    = |item.data_value;
	assign rx_match = (mode == cmm_pkg::MODE_SPY) ||
		(item.rx_extended == st.ext && item.rx_id == st.id);

	// periodic timer only counts when nothing is already queued
	assign due = st.pending ||
		(mode != cmm_pkg::MODE_CHANGE && elapsed >= period);

	always_comb begin
		nxt = st;
		tx  = 1'b0;
		case (cmm_pkg::cmd_t'(item.command))
			cmm_pkg::CMD_POLL: begin
				if (mode == cmm_pkg::MODE_READ || mode == cmm_pkg::MODE_SPY) begin
					nxt.fresh = 1'b0;
					if (item.rx_valid && rx_match) begin
						nxt.id    = item.rx_id;
						nxt.ext   = item.rx_extended;
						nxt.fresh = 1'b1;
						nxt.ts    = item.rx_timestamp;
						nxt.len   = (item.rx_len > cmm_pkg::MAX_LEN) ?
							cmm_pkg::MAX_LEN : item.rx_len;
						nxt.data  = item.rx_data;
					end
				end else if (due) begin
					tx            = 1'b1;
					nxt.pending   = 1'b0;
					nxt.last_send = item.now_ms;
				end
			end
			cmm_pkg::CMD_SET: begin
				if (!item.byte_index[3] && old_byte != item.data_value) begin
					nxt.data[sh +: 8] = item.data_value;
					if (mode != cmm_pkg::MODE_PERIODIC)
						nxt.pending = 1'b1;
				end
			end
			cmm_pkg::CMD_TRIG: begin
				if (level && !st.prev_trig)
					nxt.pending = 1'b1;
				nxt.prev_trig = level;
			end
			default: begin
				nxt = st;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ bench/can_mailbox_checker.sv @@
// Checker for the CAN mailbox: tracks the stored frame and compares each result item.
`timescale 1ns / 1ps

module can_mailbox_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  cmm_pkg::cmd_item_t cmd_data,
	input  logic               res_valid,
	input  logic               res_ready,
	input  cmm_pkg::res_item_t res_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  cmm_pkg::cfg_item_t cfg_data,
	output int                 fail_count,
	output int                 pending_results
);

	cmm_pkg::state_t            mbx;
	cmm_pkg::mode_t             mode_reg;
	logic [cmm_pkg::TIME_W-1:0] period_reg;
	cmm_pkg::res_item_t         frames_due[$];

	initial fail_count = 0;

	task automatic clear_mailbox();
		mbx        = '0;
		mbx.len    = cmm_pkg::MAX_LEN;
		mode_reg   = cmm_pkg::MODE_READ;
		period_reg = cmm_pkg::RST_PERIOD_MS;
	endtask

	task automatic write_register(input cmm_pkg::cfg_item_t w);
		case (w.index)
			cmm_pkg::REG_MODE: begin
				if (w.wdata[2:0] <= cmm_pkg::MODE_BOTH)
					mode_reg = cmm_pkg::mode_t'(w.wdata[2:0]);
			end
			cmm_pkg::REG_FRAME_ID: mbx.id = w.wdata[cmm_pkg::ID_W-1:0];
			cmm_pkg::REG_EXTENDED: mbx.ext = w.wdata[0];
			cmm_pkg::REG_LENGTH: begin
				if (w.wdata[cmm_pkg::LEN_W-1:0] >= cmm_pkg::MIN_LEN &&
					w.wdata[cmm_pkg::LEN_W-1:0] <= cmm_pkg::MAX_LEN)
					mbx.len = w.wdata[cmm_pkg::LEN_W-1:0];
			end
			cmm_pkg::REG_PERIOD: period_reg = w.wdata;
			default: ;
		endcase
	endtask

	// Applies one command item to the mailbox and returns the frame as it then stands
	task automatic step_mailbox(input cmm_pkg::cmd_item_t it, output cmm_pkg::res_item_t r);
		logic [cmm_pkg::TIME_W-1:0] elapsed;
		logic                       hit;
		logic                       level;
		logic                       sent;
		logic [7:0]                 old_byte;
		sent = 1'b0;
		case (it.command)
			cmm_pkg::CMD_POLL: begin
				if (mode_reg == cmm_pkg::MODE_READ || mode_reg == cmm_pkg::MODE_SPY) begin
					mbx.fresh = 1'b0;
					if (it.rx_valid) begin
						if (mode_reg == cmm_pkg::MODE_SPY) begin
							mbx.ext = it.rx_extended;
							mbx.id  = it.rx_id;
							hit     = 1'b1;
						end else begin
							hit = (it.rx_extended == mbx.ext) && (it.rx_id == mbx.id);
						end
						if (hit) begin
							mbx.fresh = 1'b1;
							mbx.ts    = it.rx_timestamp;
							mbx.len   = (it.rx_len > cmm_pkg::MAX_LEN) ?
								cmm_pkg::MAX_LEN : it.rx_len;
							mbx.data  = it.rx_data;
						end
					end
				end else begin
					elapsed = it.now_ms - mbx.last_send;
					if (mode_reg != cmm_pkg::MODE_CHANGE && !mbx.pending &&
						elapsed >= period_reg)
						mbx.pending = 1'b1;
					if (mbx.pending) begin
						mbx.last_send = it.now_ms;
						mbx.pending   = 1'b0;
						sent          = 1'b1;
					end
				end
			end
			cmm_pkg::CMD_SET: begin
				if (it.byte_index <= {1'b0, cmm_pkg::LAST_BYTE}) begin
					old_byte = mbx.data[{it.byte_index[2:0], 3'b000} +: 8];
					if (old_byte != it.data_value) begin
						mbx.data[{it.byte_index[2:0], 3'b000} +: 8] = it.data_value;
						// periodic-only mode leaves the send to the timer
						if (mode_reg != cmm_pkg::MODE_PERIODIC)
							mbx.pending = 1'b1;
					end
				end
			end
			cmm_pkg::CMD_TRIG: begin
				level = |it.data_value;
				if (level && !mbx.prev_trig)
					mbx.pending = 1'b1;
				mbx.prev_trig = level;
			end
			default: ;
		endcase
		r.tx_valid        = sent;
		r.frame_id        = mbx.id;
		r.frame_extended  = mbx.ext;
		r.frame_len       = mbx.len;
		r.frame_data      = mbx.data;
		r.new_data        = mbx.fresh;
		r.frame_timestamp = mbx.ts;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmm_pkg::res_item_t want;
		cmm_pkg::res_item_t next_frame;
		if (!arst_n) begin
			clear_mailbox();
			frames_due.delete();
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_data);
			if (res_valid && res_ready) begin
				if (frames_due.size() == 0) begin
					fail_count++;
					$display("%0t: result item with none expected, actual %h", $time, res_data);
				end else begin
					want = frames_due.pop_front();
					check_field("tx_valid", 64'(want.tx_valid), 64'(res_data.tx_valid));
					check_field("frame_id", 64'(want.frame_id), 64'(res_data.frame_id));
					check_field("frame_extended", 64'(want.frame_extended),
						64'(res_data.frame_extended));
					check_field("frame_len", 64'(want.frame_len), 64'(res_data.frame_len));
					check_field("frame_data", want.frame_data, res_data.frame_data);
					check_field("new_data", 64'(want.new_data), 64'(res_data.new_data));
					check_field("frame_timestamp", 64'(want.frame_timestamp),
						64'(res_data.frame_timestamp));
				end
			end
			if (cmd_valid && cmd_ready) begin
				step_mailbox(cmd_data, next_frame);
				frames_due.push_back(next_frame);
			end
			pending_results = frames_due.size();
		end
	end

endmodule

@@ bench/can_message_mailbox_tb.sv @@
// Testbench top for the CAN mailbox: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module can_message_mailbox_tb;

	localparam int          PHASES          = 10;
	localparam int          ITEMS_PER_PHASE = 53;
	localparam int          HOLD_CYCLES     = 200;
	localparam logic [1:0]  CMD_SPARE       = 2'd3;
	localparam logic [2:0]  REG_SPARE       = 3'd7;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_results;

	logic                       bursty;
	logic                       hold_req;
	cmm_pkg::mode_t             run_mode;
	logic [cmm_pkg::ID_W-1:0]   cur_id;
	logic                       cur_ext;
	logic [cmm_pkg::TIME_W-1:0] ms_clock;

	cmm_chan_if #(.T(cmm_pkg::cmd_item_t)) cmd_ch ();
	cmm_chan_if #(.T(cmm_pkg::res_item_t)) res_ch ();
	cmm_chan_if #(.T(cmm_pkg::cfg_item_t)) cfg_ch ();

	can_message_mailbox u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	can_mailbox_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_ch.valid),
		.cmd_ready       (cmd_ch.ready),
		.cmd_data        (cmd_ch.data),
		.res_valid       (res_ch.valid),
		.res_ready       (res_ch.ready),
		.res_data        (res_ch.data),
		.cfg_valid       (cfg_ch.valid),
		.cfg_ready       (cfg_ch.ready),
		.cfg_data        (cfg_ch.data),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (bursty && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// valid stays high into the next item unless a gap is drawn
	task automatic send_cmd(input cmm_pkg::cmd_item_t it);
		if (bursty && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= it;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// Only written once every result is back and the pipeline has drained
	task automatic write_reg(input logic [2:0] idx, input logic [cmm_pkg::CFG_W-1:0] value);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_results == 0);
		repeat (3) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, wdata: value};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic cmm_pkg::cmd_item_t random_item();
		cmm_pkg::cmd_item_t it;
		int unsigned        pick;
		it.command      = cmm_pkg::CMD_POLL;
		it.now_ms       = ms_clock;
		it.byte_index   = 4'($urandom_range(0, 15));
		it.data_value   = 8'($urandom_range(0, 255));
		it.rx_valid     = ($urandom_range(0, 9) != 0);
		it.rx_id        = 29'($urandom());
		it.rx_extended  = 1'($urandom_range(0, 1));
		it.rx_len       = 4'($urandom_range(0, 15));
		it.rx_data      = {$urandom(), $urandom()};
		it.rx_timestamp = 16'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			// mostly matching frames so read mode actually takes some
			if (run_mode == cmm_pkg::MODE_READ && $urandom_range(0, 3) != 0) begin
				it.rx_id       = cur_id;
				it.rx_extended = cur_ext;
			end
		end else if (pick < 80) begin
			it.command = cmm_pkg::CMD_SET;
			if ($urandom_range(0, 4) != 0)
				it.byte_index = 4'($urandom_range(0, 7));
			if ($urandom_range(0, 1) == 0)
				it.data_value = 8'($urandom_range(0, 3));
		end else if (pick < 95) begin
			it.command = cmm_pkg::CMD_TRIG;
			if ($urandom_range(0, 1) == 0)
				it.data_value = '0;
		end else begin
			it.command = CMD_SPARE;
		end
		return it;
	endfunction

	initial begin
		cmm_pkg::cmd_item_t          d;
		logic [cmm_pkg::CFG_W-1:0]   junk;
		logic [cmm_pkg::CFG_W-1:0]   phase_period[PHASES];
		logic [cmm_pkg::LEN_W-1:0]   phase_len[PHASES];
		cmm_pkg::mode_t              phase_mode[PHASES];

		phase_mode   = '{cmm_pkg::MODE_READ, cmm_pkg::MODE_SPY, cmm_pkg::MODE_CHANGE,
			cmm_pkg::MODE_PERIODIC, cmm_pkg::MODE_BOTH, cmm_pkg::MODE_PERIODIC,
			cmm_pkg::MODE_BOTH, cmm_pkg::MODE_SPY, cmm_pkg::MODE_CHANGE, cmm_pkg::MODE_READ};
		phase_period = '{32'd1000, 32'd0, 32'd25, 32'd0, 32'd1, 32'd25, 32'hFFFF_FFFF,
			32'd40, 32'd7, 32'd1000};
		phase_len    = '{4'd1, 4'd8, 4'd3, 4'd8, 4'd5, 4'd1, 4'd2, 4'd8, 4'd6, 4'd4};

		arst_n       = 1'b0;
		bursty       = 1'b1;
		hold_req     = 1'b0;
		run_mode     = cmm_pkg::MODE_READ;
		cur_id       = '0;
		cur_ext      = 1'b0;
		ms_clock     = '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset settings
		d              = '0;
		d.command      = cmm_pkg::CMD_POLL;
		d.rx_valid     = 1'b1;
		d.rx_len       = cmm_pkg::MAX_LEN;
		d.rx_data      = '1;
		d.rx_timestamp = '1;
		send_cmd(d);
		d.rx_extended  = 1'b1;              // format differs
		send_cmd(d);
		d.rx_extended  = 1'b0;
		d.rx_id        = '1;                // identifier differs
		send_cmd(d);
		d.rx_id        = '0;
		d.rx_len       = 4'hF;              // clipped to eight
		d.rx_data      = 64'h0123_4567_89AB_CDEF;
		d.rx_timestamp = '0;
		send_cmd(d);
		d.rx_len       = '0;
		send_cmd(d);
		d.rx_valid     = 1'b0;
		send_cmd(d);

		d = '0;
		d.command    = cmm_pkg::CMD_SET;
		d.data_value = 8'hEF;               // same byte, no change
		send_cmd(d);
		d.data_value = 8'h00;
		send_cmd(d);
		d.byte_index = 4'd7;
		d.data_value = 8'hFF;
		send_cmd(d);
		d.byte_index = 4'd8;
		d.data_value = 8'h55;
		send_cmd(d);
		d.byte_index = 4'hF;
		send_cmd(d);

		d = '0;
		d.command = cmm_pkg::CMD_TRIG;
		foreach (junk[i]) if (i < 4) begin
			d.data_value = (i == 0) ? 8'h01 : (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'h80;
			send_cmd(d);
		end

		d         = '1;
		d.command = CMD_SPARE;
		send_cmd(d);

		write_reg(cmm_pkg::REG_MODE, {29'd0, cmm_pkg::MODE_SPY});
		d = '0;
		d.command      = cmm_pkg::CMD_POLL;
		d.rx_valid     = 1'b1;
		d.rx_id        = '1;
		d.rx_extended  = 1'b1;
		d.rx_len       = 4'd3;
		d.rx_data      = 64'hFEDC_BA98_7654_3210;
		d.rx_timestamp = 16'h8001;
		send_cmd(d);

		// a change left pending in read mode goes out on the first poll
		write_reg(cmm_pkg::REG_MODE, {29'd0, cmm_pkg::MODE_CHANGE});
		d = '0;
		d.command = cmm_pkg::CMD_POLL;
		send_cmd(d);
		send_cmd(d);
		write_reg(cmm_pkg::REG_MODE, {29'd0, cmm_pkg::MODE_BOTH});
		d.now_ms = '1;
		send_cmd(d);
		send_cmd(d);

		for (int p = 0; p < PHASES; p++) begin
			run_mode = phase_mode[p];
			bursty   = (p != PHASES - 1);
			cur_id   = (p == 0) ? '1 : 29'($urandom());
			cur_ext  = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
			write_reg(cmm_pkg::REG_FRAME_ID, {3'b000, cur_id});
			write_reg(cmm_pkg::REG_EXTENDED, {31'($urandom()), cur_ext});
			write_reg(cmm_pkg::REG_LENGTH, {28'd0, phase_len[p]});
			write_reg(cmm_pkg::REG_PERIOD, phase_period[p]);
			write_reg(cmm_pkg::REG_MODE, {29'd0, run_mode});
			// values the registers must refuse
			junk      = $urandom();
			junk[2:0] = 3'($urandom_range(5, 7));
			write_reg(cmm_pkg::REG_MODE, junk);
			junk      = $urandom();
			junk[3:0] = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
			write_reg(cmm_pkg::REG_LENGTH, junk);
			if (p % 3 == 0)
				write_reg(REG_SPARE, $urandom());
			if (p == 2)
				hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				ms_clock = ms_clock + (($urandom_range(0, 7) == 0) ? $urandom()
					: $urandom_range(0, 40));
				send_cmd(random_item());
			end
		end

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_results == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
